// ===== hw/rtl/sbot_pkg.sv =====
package sbot_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned NumAxes = 3;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [2:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MIN_Y = 3'd1,
      REG_BOX_MIN_Z = 3'd2,
      REG_BOX_MAX_X = 3'd3,
      REG_BOX_MAX_Y = 3'd4,
      REG_BOX_MAX_Z = 3'd5
   } csr_index_type;

   // Each cross axis pairs two box axes: first and second member of the pair.
   localparam int unsigned CrossFirst[NumAxes] = '{1, 2, 0};
   localparam int unsigned CrossSecond[NumAxes] = '{2, 0, 1};

endpackage

// ===== hw/rtl/sbot_chan_if.sv =====
interface sbot_req_if;
   import sbot_pkg::*;

   logic      valid;
   logic      ready;
   coord_type seg_start_x;
   coord_type seg_start_y;
   coord_type seg_start_z;
   coord_type seg_end_x;
   coord_type seg_end_y;
   coord_type seg_end_z;

   modport source (
      output valid, seg_start_x, seg_start_y, seg_start_z,
      output seg_end_x, seg_end_y, seg_end_z,
      input  ready
   );

   modport sink (
      input  valid, seg_start_x, seg_start_y, seg_start_z,
      input  seg_end_x, seg_end_y, seg_end_z,
      output ready
   );
endinterface

interface sbot_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

// ===== hw/rtl/segment_box_overlap_test_unit.sv =====
// Segment versus axis-aligned box overlap test. Each request carries one
// segment (start and end point, signed Q16.16) and yields one response whose
// hit bit is set unless one of the three box axes or the three cross axes
// separates the segment from the box; a segment that only touches the box
// counts as a hit. The box corners are set through the APB-style register
// port and must only be written while no request is in flight. The unit is
// a five-stage pipeline that takes one request every cycle unless backpressure
// stalls it; each request passes through the s1, s2, s3, s4 and output
// registers in order before its response is offered. The multiplier stage with
// twelve products of up to 33 by 35 bits sets the clock. Backpressure holds
// each stage in place, and empty stages fill in behind a stalled one.
module segment_box_overlap_test_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   sbot_req_if.sink                             req_bus,
   sbot_rsp_if.source                           rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sbot_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [sbot_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [sbot_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import sbot_pkg::*;

   coord_type box_min_ff [NumAxes];
   coord_type box_max_ff [NumAxes];
   csr_index_type csr_index;
   logic csr_write;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_move, s2_move, s3_move, s4_move, out_move;

   logic signed [32:0] e2_in [NumAxes];
   logic signed [32:0] d2_in [NumAxes];
   logic signed [33:0] r2_in [NumAxes];
   logic signed [32:0] e2_ff [NumAxes];
   logic signed [32:0] d2_ff [NumAxes];
   logic signed [33:0] r2_ff [NumAxes];

   logic               s2_hit_in;
   logic [33:0]        absd_in [NumAxes];
   logic               s2_hit_ff;
   logic signed [32:0] s2_e2_ff [NumAxes];
   logic signed [32:0] s2_d2_ff [NumAxes];
   logic signed [33:0] s2_r2_ff [NumAxes];
   logic [33:0]        absd_ff [NumAxes];

   logic signed [66:0] pdr_a_in [NumAxes];
   logic signed [66:0] pdr_b_in [NumAxes];
   logic signed [67:0] ped_a_in [NumAxes];
   logic signed [67:0] ped_b_in [NumAxes];
   logic               s3_hit_ff;
   logic signed [66:0] pdr_a_ff [NumAxes];
   logic signed [66:0] pdr_b_ff [NumAxes];
   logic signed [67:0] ped_a_ff [NumAxes];
   logic signed [67:0] ped_b_ff [NumAxes];

   logic signed [68:0] cross_in [NumAxes];
   logic signed [68:0] lim_in [NumAxes];
   logic               s4_hit_ff;
   logic signed [68:0] cross_ff [NumAxes];
   logic signed [68:0] lim_ff [NumAxes];

   logic out_hit_in;
   logic out_hit_ff;

   assign csr_index = csr_index_type'(csr_paddr[4:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_BOX_MIN_X: csr_prdata = box_min_ff[0];
         REG_BOX_MIN_Y: csr_prdata = box_min_ff[1];
         REG_BOX_MIN_Z: csr_prdata = box_min_ff[2];
         REG_BOX_MAX_X: csr_prdata = box_max_ff[0];
         REG_BOX_MAX_Y: csr_prdata = box_max_ff[1];
         REG_BOX_MAX_Z: csr_prdata = box_max_ff[2];
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumAxes; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BOX_MIN_X: box_min_ff[0] <= csr_pwdata;
            REG_BOX_MIN_Y: box_min_ff[1] <= csr_pwdata;
            REG_BOX_MIN_Z: box_min_ff[2] <= csr_pwdata;
            REG_BOX_MAX_X: box_max_ff[0] <= csr_pwdata;
            REG_BOX_MAX_Y: box_max_ff[1] <= csr_pwdata;
            REG_BOX_MAX_Z: box_max_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   assign out_move = !out_valid_ff || rsp_bus.ready;
   assign s4_move = !s4_valid_ff || out_move;
   assign s3_move = !s3_valid_ff || s4_move;
   assign s2_move = !s2_valid_ff || s3_move;
   assign s1_move = !s1_valid_ff || s2_move;
   assign req_bus.ready = s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_move) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_move) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_move) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Doubled half-extents, half-directions and center offsets.
   always_comb begin
      coord_type seg_s [NumAxes];
      coord_type seg_e [NumAxes];
      seg_s[0] = req_bus.seg_start_x;
      seg_s[1] = req_bus.seg_start_y;
      seg_s[2] = req_bus.seg_start_z;
      seg_e[0] = req_bus.seg_end_x;
      seg_e[1] = req_bus.seg_end_y;
      seg_e[2] = req_bus.seg_end_z;
      for (int i = 0; i < NumAxes; i++) begin
         e2_in[i] = 33'(box_max_ff[i]) - 33'(box_min_ff[i]);
         d2_in[i] = 33'(seg_e[i]) - 33'(seg_s[i]);
         r2_in[i] = (34'(seg_e[i]) + 34'(seg_s[i]))
                  - (34'(box_max_ff[i]) + 34'(box_min_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         e2_ff <= e2_in;
         d2_ff <= d2_in;
         r2_ff <= r2_in;
      end
   end

   always_comb begin
      logic signed [33:0] dw;
      logic signed [34:0] rw;
      logic [34:0]        absr;
      s2_hit_in = 1'b1;
      for (int i = 0; i < NumAxes; i++) begin
         dw = 34'(d2_ff[i]);
         rw = 35'(r2_ff[i]);
         absd_in[i] = dw[33] ? 34'(-dw) : 34'(dw);
         absr = rw[34] ? 35'(-rw) : 35'(rw);
         if ($signed({1'b0, absr}) > 36'(e2_ff[i]) + $signed({2'b00, absd_in[i]})) begin
            s2_hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s2_hit_ff <= s2_hit_in;
         s2_e2_ff <= e2_ff;
         s2_d2_ff <= d2_ff;
         s2_r2_ff <= r2_ff;
         absd_ff <= absd_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         pdr_a_in[k] = s2_d2_ff[CrossFirst[k]] * s2_r2_ff[CrossSecond[k]];
         pdr_b_in[k] = s2_d2_ff[CrossSecond[k]] * s2_r2_ff[CrossFirst[k]];
         ped_a_in[k] = s2_e2_ff[CrossFirst[k]] * $signed({1'b0, absd_ff[CrossSecond[k]]});
         ped_b_in[k] = s2_e2_ff[CrossSecond[k]] * $signed({1'b0, absd_ff[CrossFirst[k]]});
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         s3_hit_ff <= s2_hit_ff;
         pdr_a_ff <= pdr_a_in;
         pdr_b_ff <= pdr_b_in;
         ped_a_ff <= ped_a_in;
         ped_b_ff <= ped_b_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         cross_in[k] = 69'(pdr_a_ff[k]) - 69'(pdr_b_ff[k]);
         lim_in[k] = 69'(ped_a_ff[k]) + 69'(ped_b_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_move) begin
         s4_hit_ff <= s3_hit_ff;
         cross_ff <= cross_in;
         lim_ff <= lim_in;
      end
   end

   always_comb begin
      logic signed [69:0] cw;
      logic signed [69:0] absc;
      out_hit_in = s4_hit_ff;
      for (int k = 0; k < NumAxes; k++) begin
         cw = 70'(cross_ff[k]);
         absc = cw[69] ? -cw : cw;
         if (absc > 70'(lim_ff[k])) begin
            out_hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_move) begin
         out_hit_ff <= out_hit_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.hit = out_hit_ff;

endmodule

// ===== hw/rtl/sbot_checker.sv =====
module sbot_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_pready
);

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered right after reset");

   // With the output side always ready, each request comes out as a response.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after pipeline latency");

   // Without output backpressure the input side never stalls.
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_ready) && rsp_ready |-> req_ready)
      else $error("request stalled while response side ready");

   assert property (@(posedge clock) csr_pready)
      else $error("register port not ready");

endmodule

bind segment_box_overlap_test_unit sbot_checker u_sbot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .csr_pready (csr_pready)
);

// ===== dv/segment_hit_checker.sv =====
module segment_hit_checker (
   input  logic                              clock,
   input  logic                              reset,
   sbot_req_if                               req_mon,
   sbot_rsp_if                               rsp_mon,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sbot_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [sbot_pkg::CsrDataWidth-1:0] csr_pwdata,
   input  logic [sbot_pkg::CsrDataWidth-1:0] csr_prdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import sbot_pkg::*;

   coord_type box_lo [NumAxes];
   coord_type box_hi [NumAxes];
   logic      expected_hits [$];

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [127:0] wide_magnitude(input logic signed [127:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // Extents, directions and offsets are all kept at twice their true value,
   // so every comparison stays exact in integer arithmetic.
   function automatic logic predict_hit(input coord_type seg_s [NumAxes],
                                        input coord_type seg_e [NumAxes]);
      longint              ext [NumAxes];
      longint              dir [NumAxes];
      longint              off [NumAxes];
      logic signed [127:0] da, db, ra, rb, ea, eb;
      logic signed [127:0] cross_dist, reach;
      int                  a, b;
      logic                hit;
      hit = 1'b1;
      for (int i = 0; i < NumAxes; i++) begin
         ext[i] = longint'(box_hi[i]) - longint'(box_lo[i]);
         dir[i] = longint'(seg_e[i]) - longint'(seg_s[i]);
         off[i] = (longint'(seg_e[i]) + longint'(seg_s[i]))
                - (longint'(box_hi[i]) + longint'(box_lo[i]));
         if (magnitude(off[i]) > ext[i] + magnitude(dir[i])) begin
            hit = 1'b0;
         end
      end
      for (int i = 0; i < NumAxes; i++) begin
         a = (i + 1) % NumAxes;
         b = (i + 2) % NumAxes;
         da = dir[a];
         db = dir[b];
         ra = off[a];
         rb = off[b];
         ea = ext[a];
         eb = ext[b];
         cross_dist = wide_magnitude(da * rb - db * ra);
         reach = ea * $signed(wide_magnitude(db)) + eb * $signed(wide_magnitude(da));
         if (cross_dist > reach) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   task automatic note_failure(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s error: expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      coord_type                 seg_s [NumAxes];
      coord_type                 seg_e [NumAxes];
      int unsigned               reg_index;
      logic                      want_hit;
      logic [CsrDataWidth-1:0]   want_word;
      if (reset) begin
         expected_hits.delete();
         fail_count = 0;
         for (int i = 0; i < NumAxes; i++) begin
            box_lo[i] = '0;
            box_hi[i] = '0;
         end
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_hits.size() == 0) begin
               note_failure("unrequested response", 64'bx, 64'(rsp_mon.hit));
            end else begin
               want_hit = expected_hits.pop_front();
               if (rsp_mon.hit !== want_hit) begin
                  note_failure("hit", 64'(want_hit), 64'(rsp_mon.hit));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            seg_s = '{req_mon.seg_start_x, req_mon.seg_start_y, req_mon.seg_start_z};
            seg_e = '{req_mon.seg_end_x, req_mon.seg_end_y, req_mon.seg_end_z};
            expected_hits.push_back(predict_hit(seg_s, seg_e));
         end
         if (csr_psel && csr_penable && csr_pready) begin
            reg_index = int'(csr_paddr >> 2);
            if (csr_pwrite) begin
               if (reg_index <= REG_BOX_MIN_Z) begin
                  box_lo[reg_index] = csr_pwdata;
               end else if (reg_index <= REG_BOX_MAX_Z) begin
                  box_hi[reg_index - REG_BOX_MAX_X] = csr_pwdata;
               end
            end else if (reg_index <= REG_BOX_MAX_Z) begin
               want_word = (reg_index <= REG_BOX_MIN_Z) ? box_lo[reg_index]
                                                        : box_hi[reg_index - REG_BOX_MAX_X];
               if (csr_prdata !== want_word) begin
                  note_failure("register read", 64'(want_word), 64'(csr_prdata));
               end
            end
         end
      end
      pending_count = expected_hits.size();
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sbot_pkg::*;

   localparam int          Unit       = 65536;
   localparam int unsigned NumBoxRegs = 6;
   localparam int          LongHold   = 64;
   localparam int          CycleLimit = 200000;
   localparam coord_type   CoordMin   = {1'b1, {(CoordWidth-1){1'b0}}};
   localparam coord_type   CoordMax   = {1'b0, {(CoordWidth-1){1'b1}}};

   logic                    clock;
   logic                    reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;
   int                      fail_count;
   int                      pending_count;

   coord_type stim_lo [NumAxes];
   coord_type stim_hi [NumAxes];
   bit        send_steady = 1'b0;
   bit        take_steady = 1'b0;
   bit        long_hold_req = 1'b0;

   sbot_req_if req_bus ();
   sbot_rsp_if rsp_bus ();

   segment_box_overlap_test_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   segment_hit_checker hit_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            repeat (LongHold) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            if ($urandom_range(0, 15) == 0) begin
               take_steady = !take_steady;
            end
            stall = take_steady ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   function automatic coord_type clip_coord(input longint v);
      if (v > CoordMax) begin
         return CoordMax;
      end
      if (v < CoordMin) begin
         return CoordMin;
      end
      return coord_type'(v);
   endfunction

   function automatic coord_type pick_coord(input int axis);
      longint          lo, hi, centre, span, offset;
      longint unsigned draw;
      lo = stim_lo[axis];
      hi = stim_hi[axis];
      case ($urandom_range(0, 15))
         0: begin
            return coord_type'($urandom);
         end
         1: begin
            case ($urandom_range(0, 4))
               0: return CoordMin;
               1: return CoordMax;
               2: return '0;
               3: return '1;
               default: return coord_type'(1);
            endcase
         end
         2: begin
            return $urandom_range(0, 1) ? stim_lo[axis] : stim_hi[axis];
         end
         default: begin
            centre = (lo + hi) >>> 1;
            span = ((hi > lo) ? hi - lo : lo - hi) + 2;
            draw = {$urandom, $urandom};
            offset = longint'(draw % longint'(4 * span + 1));
            return clip_coord(centre + offset - 2 * span);
         end
      endcase
   endfunction

   task automatic send_segment(input coord_type sx, input coord_type sy, input coord_type sz,
                               input coord_type ex, input coord_type ey, input coord_type ez);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         send_steady = !send_steady;
      end
      gap = send_steady ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.seg_start_x <= sx;
      req_bus.seg_start_y <= sy;
      req_bus.seg_start_z <= sz;
      req_bus.seg_end_x   <= ex;
      req_bus.seg_end_y   <= ey;
      req_bus.seg_end_z   <= ez;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int hold_at);
      coord_type seg_s [NumAxes];
      coord_type seg_e [NumAxes];
      int        axis;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) begin
            long_hold_req = 1'b1;
            send_steady = 1'b1;
         end
         for (int i = 0; i < NumAxes; i++) begin
            seg_s[i] = pick_coord(i);
            seg_e[i] = pick_coord(i);
         end
         if ($urandom_range(0, 15) == 0) begin
            seg_e = seg_s;
         end else if ($urandom_range(0, 7) == 0) begin
            axis = $urandom_range(0, NumAxes - 1);
            seg_e[axis] = seg_s[axis];
         end
         send_segment(seg_s[0], seg_s[1], seg_s[2], seg_e[0], seg_e[1], seg_e[2]);
      end
   endtask

   task automatic csr_access(input logic write, input int unsigned index,
                             input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CsrAddrWidth'(index << 2);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic read_back_all();
      for (int i = 0; i < NumBoxRegs; i++) begin
         csr_access(1'b0, i, '0);
      end
   endtask

   task automatic load_box(input coord_type lx, input coord_type ly, input coord_type lz,
                           input coord_type hx, input coord_type hy, input coord_type hz);
      stim_lo = '{lx, ly, lz};
      stim_hi = '{hx, hy, hz};
      csr_access(1'b1, REG_BOX_MIN_X, lx);
      csr_access(1'b1, REG_BOX_MIN_Y, ly);
      csr_access(1'b1, REG_BOX_MIN_Z, lz);
      csr_access(1'b1, REG_BOX_MAX_X, hx);
      csr_access(1'b1, REG_BOX_MAX_Y, hy);
      csr_access(1'b1, REG_BOX_MAX_Z, hz);
      read_back_all();
   endtask

   task automatic random_box();
      longint    centre, half;
      coord_type lo [NumAxes];
      coord_type hi [NumAxes];
      coord_type swap;
      for (int i = 0; i < NumAxes; i++) begin
         centre = longint'($signed($urandom)) >>> $urandom_range(0, 12);
         half = longint'($urandom_range(0, 1 << 20)) << $urandom_range(0, 10);
         lo[i] = clip_coord(centre - half);
         hi[i] = clip_coord(centre + half);
         if ($urandom_range(0, 5) == 0) begin
            swap = lo[i];
            lo[i] = hi[i];
            hi[i] = swap;
         end
      end
      load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   // The block may take new box corners only once every response is out.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_bus.valid       = 1'b0;
      req_bus.seg_start_x = '0;
      req_bus.seg_start_y = '0;
      req_bus.seg_start_z = '0;
      req_bus.seg_end_x   = '0;
      req_bus.seg_end_y   = '0;
      req_bus.seg_end_z   = '0;
      stim_lo             = '{default: '0};
      stim_hi             = '{default: '0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      read_back_all();
      run_random(60, -1);

      wait_drained();
      load_box(-10 * Unit, -10 * Unit, -10 * Unit, 10 * Unit, 10 * Unit, 10 * Unit);
      send_segment(-1 * Unit, -2 * Unit, -3 * Unit, 4 * Unit, 5 * Unit, 6 * Unit);
      send_segment(-30 * Unit, 0, 0, 30 * Unit, 0, 0);
      send_segment(11 * Unit, 0, 0, 20 * Unit, 5 * Unit, 5 * Unit);
      send_segment(10 * Unit, 0, 0, 10 * Unit, 0, 0);
      send_segment(10 * Unit + 1, 0, 0, 10 * Unit + 1, 0, 0);
      send_segment(20 * Unit, 3 * Unit, 3 * Unit, 10 * Unit, 3 * Unit, 3 * Unit);
      send_segment(0, 25 * Unit, 0, 25 * Unit, 0, 0);
      send_segment(0, 20 * Unit, 0, 20 * Unit, 0, 0);
      send_segment(0, 0, 25 * Unit, 0, 25 * Unit, 0);
      send_segment(25 * Unit, 0, 0, 0, 0, 25 * Unit);
      send_segment(0, 25 * Unit, 5 * Unit, 25 * Unit, 0, 5 * Unit);
      send_segment(Unit, Unit, Unit, Unit, Unit, Unit);
      send_segment(0, 0, -11 * Unit, 0, 0, -11 * Unit);
      send_segment(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
      send_segment(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
      send_segment(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
      send_segment(-1, -1, -1, -1, -1, -1);
      send_segment(CoordMax, CoordMin, 0, CoordMin, CoordMax, 0);
      send_segment(CoordMin, 0, 0, CoordMin, CoordMax, CoordMax);
      send_segment(11 * Unit, 11 * Unit, -30 * Unit, 11 * Unit, 11 * Unit, 30 * Unit);
      run_random(100, 50);

      wait_drained();
      load_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
      run_random(80, -1);

      wait_drained();
      load_box(5 * Unit, -20 * Unit, -3 * Unit, -5 * Unit, 20 * Unit, 3 * Unit);
      csr_access(1'b1, NumBoxRegs, $urandom);
      csr_access(1'b1, NumBoxRegs + 1, $urandom);
      read_back_all();
      run_random(100, -1);

      wait_drained();
      load_box(-8 * Unit, 3 * Unit, CoordMin, 8 * Unit, 3 * Unit, CoordMax);
      run_random(100, -1);

      wait_drained();
      load_box(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin);
      run_random(40, -1);

      for (int k = 0; k < 5; k++) begin
         wait_drained();
         random_box();
         run_random(90, (k == 2) ? 40 : -1);
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sbot_pkg.sv
hw/rtl/sbot_chan_if.sv
hw/rtl/segment_box_overlap_test_unit.sv
hw/rtl/sbot_checker.sv
dv/segment_hit_checker.sv
dv/tb_top.sv
